// ===== sv/dsa_pkg.sv =====
`default_nettype none
package dsa_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_SLOTS     = 1024;
  localparam int DEF_MAX_BATCH     = 64;
  localparam int DEF_MAP_WORD_BITS = 64;

  // field widths
  localparam int OP_W     = 3;
  localparam int COUNT_W  = 7;
  localparam int SLOT_W   = 10;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 2;
  localparam int POOL_W   = 11;
  localparam int STRIDE_W = 13;
  localparam int CFG_IDX_W = 3;

  // request codes
  localparam logic [OP_W-1:0] OP_ALLOC_ONE   = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_MANY  = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC_RANGE = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE_SLOT   = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE_ADDR   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_VISIBLE = 3'd4;

  // register reset values
  localparam logic [POOL_W-1:0]   RST_POOL_SIZE   = 11'd1024;
  localparam logic [STRIDE_W-1:0] RST_SLOT_STRIDE = 13'd32;

endpackage
`default_nettype wire

// ===== sv/descriptor_slot_allocator_top.sv =====
`default_nettype none
// First-fit slot allocator over a bitmap free map (one bit per slot, 1 = free) held in a
// single-port synchronous RAM of MAX_SLOTS/MAP_WORD_BITS words, one word read or written per
// cycle. MAP_WORD_BITS must be a power of two. Issue a request by raising start while busy is
// low; the request's words come out on the result ports, one per cycle at most, each marked
// by done for exactly one cycle, and the last one of a request has last set. The receiver
// cannot stall the result side, so it must take every word in the cycle it appears. Every
// request passes a decode state, then walks the map with a fetch (read), a load and a work
// state per map word visited: alloc one scans word by word up to the first free slot, alloc
// several takes further slots from the same word before it moves on to the next word, alloc
// range scans word by word and then walks back over the words of the run to clear them. free
// slot splits the slot number into word and bit directly; free by address first divides the
// offset by the stride in a 64-step shift-subtract divider. Each result then passes the
// capture, multiply and add registers of the address pipeline before it reaches the result
// ports. Writing pool_size starts a recount of the free slots over the map words below the
// pool size, during which busy is high. cfg_ready stays low while start or busy is high or
// result words are still in the address pipeline.
module descriptor_slot_allocator_top #(
  parameter int MAX_SLOTS     = dsa_pkg::DEF_MAX_SLOTS,
  parameter int MAX_BATCH     = dsa_pkg::DEF_MAX_BATCH,
  parameter int MAP_WORD_BITS = dsa_pkg::DEF_MAP_WORD_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request side
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [dsa_pkg::OP_W-1:0]          op,
  input  wire logic [dsa_pkg::COUNT_W-1:0]       count,
  input  wire logic [dsa_pkg::SLOT_W-1:0]        slot,
  input  wire logic [dsa_pkg::ADDR_W-1:0]        address,
  // result side
  output logic                                   done,
  output logic [dsa_pkg::STATUS_W-1:0]           status,
  output logic [dsa_pkg::SLOT_W-1:0]             slot_index,
  output logic [dsa_pkg::COUNT_W-1:0]            granted_count,
  output logic [dsa_pkg::ADDR_W-1:0]             cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]             gpu_address,
  output logic                                   gpu_valid,
  output logic                                   last,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dsa_pkg::ADDR_W-1:0]        cfg_data
);
  import dsa_pkg::*;

  localparam int WB    = MAP_WORD_BITS;
  localparam int WORDS = (MAX_SLOTS + WB - 1) / WB;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW    = (WB > 1) ? $clog2(WB) : 1;
  // wide enough for any slot number, the word base past the end, and the free count
  localparam int CW    = $clog2(WORDS * WB + WB + 1);
  localparam int DIVN  = ADDR_W;
  localparam int DCW   = $clog2(DIVN);
  localparam int PW    = CW + STRIDE_W;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_LOAD   = 4'd4;
  localparam logic [3:0] S_ALLOC  = 4'd5;
  localparam logic [3:0] S_RANGE  = 4'd6;
  localparam logic [3:0] S_CLEAR  = 4'd7;
  localparam logic [3:0] S_FREE   = 4'd8;
  localparam logic [3:0] S_RCNT   = 4'd9;

  // configuration registers
  logic [POOL_W-1:0]   pool_size;
  logic [STRIDE_W-1:0] slot_stride;
  logic [ADDR_W-1:0]   cpu_base;
  logic [ADDR_W-1:0]   gpu_base;
  logic                gpu_visible;

  // sequencer
  logic [3:0]          state;
  logic [3:0]          ret_state;
  logic [WIW-1:0]      widx;
  logic [CW-1:0]       wbase;
  logic [WB-1:0]       wbuf;
  logic [OP_W-1:0]     op_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [CW-1:0]       slot_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [COUNT_W-1:0]  remain;
  logic [COUNT_W-1:0]  carry;
  logic [CW-1:0]       rstart;
  logic [CW-1:0]       free_count;
  logic [BW-1:0]       fbit;

  // shift-subtract divider
  logic [ADDR_W-1:0]   dq;
  logic [STRIDE_W-1:0] dr;
  logic [STRIDE_W-1:0] dd;
  logic [DCW-1:0]      dcnt;

  // free map memory, with a valid bit per word so unwritten words read as all free
  logic [WB-1:0]       map_mem [WORDS];
  logic [WB-1:0]       rd_data;
  logic                rd_ok;
  logic [WORDS-1:0]    word_ok;
  logic                mem_we;
  logic [WB-1:0]       mem_wdata;

  // result pipeline: decide, multiply, add
  logic                a_v, b_v;
  logic [STATUS_W-1:0] a_status, b_status;
  logic [CW-1:0]       a_slot, b_slot;
  logic [COUNT_W-1:0]  a_cnt, b_cnt;
  logic                a_addr, b_addr, a_last, b_last;
  logic [ADDR_W-1:0]   b_prod;

  // result word decided in this cycle
  logic                emit_v;
  logic [STATUS_W-1:0] emit_status;
  logic [CW-1:0]       emit_slot;
  logic [COUNT_W-1:0]  emit_cnt;
  logic                emit_addr;
  logic                emit_last;

  // datapath
  logic [CW-1:0]       n_eff;
  logic [WB-1:0]       inpool;
  logic [WB-1:0]       cur;
  logic                low_hit;
  logic [BW-1:0]       low_idx;
  logic                rhit;
  logic [BW-1:0]       rhit_idx;
  logic [COUNT_W-1:0]  carry_next;
  logic [CW-1:0]       popcnt;
  logic [WB-1:0]       rmask;
  logic                last_word;
  logic [ADDR_W-1:0]   offset;
  logic [STRIDE_W:0]   trial;
  logic                trial_ge;
  logic [STRIDE_W-1:0] dr_next;
  logic [ADDR_W-1:0]   dq_next;
  logic [CW-1:0]       run_start;
  logic                cfg_we;
  logic                req_ok;

  assign busy      = (state != S_IDLE);
  // registers feed the address pipeline, so hold writes until it is empty
  assign cfg_ready = (state == S_IDLE) && !start && !a_v && !b_v;
  assign cfg_we    = cfg_valid && cfg_ready;

  // slots at or above this many are never handed out or freed
  assign n_eff = ({{(CW-POOL_W){1'b0}}, pool_size} > CW'(MAX_SLOTS)) ?
                 CW'(MAX_SLOTS) : {{(CW-POOL_W){1'b0}}, pool_size};

  assign last_word = (wbase + CW'(WB)) >= n_eff;
  assign offset    = addr_q - cpu_base;
  assign run_start = wbase + CW'(rhit_idx) + CW'(1) - CW'(cnt_q);

  // per-word scan logic
  always_comb begin
    logic pre;
    logic win;
    logic [BW-1:0] hz;
    logic allf;
    logic [COUNT_W:0] sat;
    for (int b = 0; b < WB; b++) begin
      inpool[b] = (wbase + CW'(b)) < n_eff;
    end
    cur = wbuf & inpool;

    // lowest free slot in the word
    low_hit = |cur;
    low_idx = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (cur[b]) begin
        low_idx = BW'(b);
      end
    end

    // lowest end position of a free run of cnt_q slots, counting the carried run
    rhit     = 1'b0;
    rhit_idx = '0;
    pre      = 1'b1;
    for (int b = WB - 1; b >= 0; b--) begin
      pre = 1'b1;
      for (int j = 0; j < WB; j++) begin
        if (j <= b) begin
          pre = pre & cur[j];
        end
      end
      win = 1'b1;
      for (int j = 0; j < WB; j++) begin
        if ((j <= b) && ((b - j) < int'(cnt_q))) begin
          win = win & cur[j];
        end
      end
      if ((pre && ((8'(carry) + 8'(b) + 8'd1) >= 8'(cnt_q))) ||
          (((b + 1) >= int'(cnt_q)) && win)) begin
        rhit     = 1'b1;
        rhit_idx = BW'(b);
      end
    end

    // free run reaching the top of the word, carried into the next one
    allf = &cur;
    hz   = '0;
    for (int b = 0; b < WB; b++) begin
      if (!cur[b]) begin
        hz = BW'(b);
      end
    end
    sat = {1'b0, carry} + (COUNT_W+1)'(WB);
    if (allf) begin
      carry_next = sat[COUNT_W] ? {COUNT_W{1'b1}} : sat[COUNT_W-1:0];
    end else begin
      carry_next = COUNT_W'(WB - 1) - COUNT_W'(hz);
    end

    popcnt = '0;
    for (int b = 0; b < WB; b++) begin
      popcnt = popcnt + CW'(cur[b]);
    end

    for (int b = 0; b < WB; b++) begin
      rmask[b] = ((wbase + CW'(b)) >= rstart) &&
                 ((wbase + CW'(b)) < (rstart + CW'(cnt_q)));
    end
  end

  // one divider step
  always_comb begin
    trial    = {dr, dq[ADDR_W-1]};
    trial_ge = trial >= {1'b0, dd};
    dr_next  = trial_ge ? STRIDE_W'(trial - {1'b0, dd}) : trial[STRIDE_W-1:0];
    dq_next  = {dq[ADDR_W-2:0], trial_ge};
  end

  assign req_ok = (cnt_q != '0) && (int'(cnt_q) <= MAX_BATCH) &&
                  (free_count >= CW'(cnt_q));

  // memory write and result decision for the current state
  always_comb begin
    mem_we      = 1'b0;
    mem_wdata   = wbuf;
    emit_v      = 1'b0;
    emit_status = ST_OK;
    emit_slot   = '0;
    emit_cnt    = '0;
    emit_addr   = 1'b0;
    emit_last   = 1'b1;
    case (state)
      S_DECODE: begin
        case (op_q)
          OP_ALLOC_ONE: begin
            if (free_count == '0) begin
              emit_v      = 1'b1;
              emit_status = ST_NO_SPACE;
            end
          end
          OP_ALLOC_MANY, OP_ALLOC_RANGE: begin
            if (!req_ok) begin
              emit_v      = 1'b1;
              emit_status = ST_NO_SPACE;
            end
          end
          OP_FREE_SLOT: begin
            if (slot_q >= n_eff) begin
              emit_v      = 1'b1;
              emit_status = ST_OUTSIDE;
            end
          end
          OP_FREE_ADDR: begin
            if ((slot_stride == '0) && ((offset != '0) || (n_eff == '0))) begin
              emit_v      = 1'b1;
              emit_status = ST_OUTSIDE;
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (dcnt == DCW'(DIVN - 1)) begin
          if (dr_next != '0) begin
            emit_v      = 1'b1;
            emit_status = ST_MISALIGNED;
          end else if (dq_next >= ADDR_W'(n_eff)) begin
            emit_v      = 1'b1;
            emit_status = ST_OUTSIDE;
          end
        end
      end
      S_ALLOC: begin
        if (low_hit) begin
          mem_we    = 1'b1;
          mem_wdata = wbuf & ~(WB'(1) << low_idx);
          emit_v    = 1'b1;
          emit_slot = wbase + CW'(low_idx);
          emit_cnt  = COUNT_W'(1);
          emit_addr = 1'b1;
          emit_last = (remain == COUNT_W'(1));
        end
      end
      S_RANGE: begin
        if (!rhit && last_word) begin
          emit_v      = 1'b1;
          emit_status = ST_NO_SPACE;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = wbuf & ~rmask;
        if (wbase <= rstart) begin
          emit_v    = 1'b1;
          emit_slot = rstart;
          emit_cnt  = cnt_q;
          emit_addr = 1'b1;
        end
      end
      S_FREE: begin
        mem_we    = !wbuf[fbit];
        mem_wdata = wbuf | (WB'(1) << fbit);
        emit_v    = 1'b1;
        emit_slot = slot_q;
      end
      default: begin
      end
    endcase
  end

  // free map ram
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[widx] <= mem_wdata;
    end
    rd_data <= map_mem[widx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret_state   <= S_IDLE;
      word_ok     <= '0;
      rd_ok       <= 1'b0;
      pool_size   <= RST_POOL_SIZE;
      slot_stride <= RST_SLOT_STRIDE;
      cpu_base    <= '0;
      gpu_base    <= '0;
      gpu_visible <= 1'b0;
      free_count  <= ({{(CW-POOL_W){1'b0}}, RST_POOL_SIZE} > CW'(MAX_SLOTS)) ?
                     CW'(MAX_SLOTS) : {{(CW-POOL_W){1'b0}}, RST_POOL_SIZE};
    end else begin
      rd_ok <= word_ok[widx];
      if (mem_we) begin
        word_ok[widx] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q   <= op;
            cnt_q  <= count;
            slot_q <= CW'(slot);
            addr_q <= address;
            state  <= S_DECODE;
          end else if (cfg_we) begin
            case (cfg_index)
              REG_POOL_SIZE: begin
                pool_size  <= cfg_data[POOL_W-1:0];
                free_count <= '0;
                widx       <= '0;
                wbase      <= '0;
                ret_state  <= S_RCNT;
                state      <= S_FETCH;
              end
              REG_SLOT_STRIDE: slot_stride <= cfg_data[STRIDE_W-1:0];
              REG_CPU_BASE:    cpu_base    <= cfg_data;
              REG_GPU_BASE:    gpu_base    <= cfg_data;
              REG_GPU_VISIBLE: gpu_visible <= cfg_data[0];
              default: begin
              end
            endcase
          end
        end
        S_DECODE: begin
          // free slot goes straight to its word, every scan starts at word zero
          widx  <= (op_q == OP_FREE_SLOT) ? WIW'(slot_q >> BW) : '0;
          wbase <= '0;
          carry <= '0;
          case (op_q)
            OP_ALLOC_ONE: begin
              if (free_count != '0) begin
                remain    <= COUNT_W'(1);
                ret_state <= S_ALLOC;
                state     <= S_FETCH;
              end else begin
                state <= S_IDLE;
              end
            end
            OP_ALLOC_MANY: begin
              if (req_ok) begin
                remain    <= cnt_q;
                ret_state <= S_ALLOC;
                state     <= S_FETCH;
              end else begin
                state <= S_IDLE;
              end
            end
            OP_ALLOC_RANGE: begin
              if (req_ok) begin
                ret_state <= S_RANGE;
                state     <= S_FETCH;
              end else begin
                state <= S_IDLE;
              end
            end
            OP_FREE_SLOT: begin
              if (slot_q < n_eff) begin
                fbit      <= BW'(slot_q);
                ret_state <= S_FREE;
                state     <= S_FETCH;
              end else begin
                state <= S_IDLE;
              end
            end
            OP_FREE_ADDR: begin
              if (slot_stride == '0) begin
                // zero stride: only the base address itself maps, to slot zero
                if ((offset == '0) && (n_eff != '0)) begin
                  slot_q    <= '0;
                  fbit      <= '0;
                  ret_state <= S_FREE;
                  state     <= S_FETCH;
                end else begin
                  state <= S_IDLE;
                end
              end else begin
                dq    <= offset;
                dd    <= slot_stride;
                dr    <= '0;
                dcnt  <= '0;
                state <= S_DIV;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_DIV: begin
          dq   <= dq_next;
          dr   <= dr_next;
          dcnt <= DCW'(dcnt + 1'b1);
          if (dcnt == DCW'(DIVN - 1)) begin
            if ((dr_next != '0) || (dq_next >= ADDR_W'(n_eff))) begin
              state <= S_IDLE;
            end else begin
              // slot found, split it into word and bit
              slot_q    <= CW'(dq_next);
              widx      <= WIW'(dq_next >> BW);
              fbit      <= BW'(dq_next);
              ret_state <= S_FREE;
              state     <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          wbuf  <= rd_ok ? rd_data : '1;
          state <= ret_state;
        end
        S_ALLOC: begin
          if (low_hit) begin
            wbuf       <= mem_wdata;
            free_count <= free_count - CW'(1);
            remain     <= remain - COUNT_W'(1);
            if (remain == COUNT_W'(1)) begin
              state <= S_IDLE;
            end
          end else begin
            widx  <= WIW'(widx + 1'b1);
            wbase <= wbase + CW'(WB);
            state <= S_FETCH;
          end
        end
        S_RANGE: begin
          if (rhit) begin
            rstart <= run_start;
            state  <= S_CLEAR;
          end else if (last_word) begin
            state <= S_IDLE;
          end else begin
            carry <= carry_next;
            widx  <= WIW'(widx + 1'b1);
            wbase <= wbase + CW'(WB);
            state <= S_FETCH;
          end
        end
        S_CLEAR: begin
          // walk back from the word where the run ended
          if (wbase <= rstart) begin
            free_count <= free_count - CW'(cnt_q);
            state      <= S_IDLE;
          end else begin
            widx      <= WIW'(widx - 1'b1);
            wbase     <= wbase - CW'(WB);
            ret_state <= S_CLEAR;
            state     <= S_FETCH;
          end
        end
        S_FREE: begin
          if (!wbuf[fbit]) begin
            free_count <= free_count + CW'(1);
          end
          state <= S_IDLE;
        end
        S_RCNT: begin
          free_count <= free_count + popcnt;
          if (last_word) begin
            state <= S_IDLE;
          end else begin
            widx  <= WIW'(widx + 1'b1);
            wbase <= wbase + CW'(WB);
            state <= S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result pipeline: capture, multiply by stride, add bases
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v  <= 1'b0;
      b_v  <= 1'b0;
      done <= 1'b0;
    end else begin
      a_v  <= emit_v;
      b_v  <= a_v;
      done <= b_v;
    end
    a_status <= emit_status;
    a_slot   <= emit_slot;
    a_cnt    <= emit_cnt;
    a_addr   <= emit_addr;
    a_last   <= emit_last;

    b_status <= a_status;
    b_slot   <= a_slot;
    b_cnt    <= a_cnt;
    b_addr   <= a_addr;
    b_last   <= a_last;
    b_prod   <= ADDR_W'(PW'(a_slot) * PW'(slot_stride));

    status        <= b_status;
    slot_index    <= b_slot[SLOT_W-1:0];
    granted_count <= b_cnt;
    cpu_address   <= b_addr ? (cpu_base + b_prod) : '0;
    gpu_address   <= (b_addr && gpu_visible) ? (gpu_base + b_prod) : '0;
    gpu_valid     <= b_addr && gpu_visible;
    last          <= b_last;
  end

  // a failed request gives exactly one word, so it must be the last one
  assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (last && (granted_count == '0)))
    else $error("failure word without last or with a grant");

  // the free count never exceeds the pool once a request or recount has finished
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (free_count <= n_eff))
    else $error("free count above pool size");

  // no gpu address leaves the block unless it is flagged valid
  assert property (@(posedge clk) disable iff (rst)
    (done && !gpu_valid) |-> (gpu_address == '0))
    else $error("gpu address without gpu valid");

endmodule
`default_nettype wire

// ===== verif/tb_descriptor_slot_allocator_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_descriptor_slot_allocator_top;
  import dsa_pkg::*;

  localparam int POOL_MAX = DEF_MAX_SLOTS;
  localparam int BATCH_MAX = DEF_MAX_BATCH;
  // longest request plus the address pipeline, with margin
  localparam int SETTLE_CYCLES = 300;

  // one result word as it leaves the block
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  granted_count;
    logic [ADDR_W-1:0]   cpu_address;
    logic [ADDR_W-1:0]   gpu_address;
    logic                gpu_valid;
    logic                last;
  } grant_word_t;

  // directed request, with a hand-written result where it is obvious
  typedef struct {
    logic [OP_W-1:0]     op;
    logic [COUNT_W-1:0]  cnt;
    logic [SLOT_W-1:0]   sl;
    logic [ADDR_W-1:0]   addr;
    bit                  typed;
    logic [STATUS_W-1:0] st;
    logic [SLOT_W-1:0]   idx;
    logic [COUNT_W-1:0]  gc;
    logic [ADDR_W-1:0]   cpu;
  } req_row_t;

  // configuration of one run phase
  typedef struct {
    logic [POOL_W-1:0]   pool;
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   cpu;
    logic [ADDR_W-1:0]   gpu;
    logic                vis;
    int                  idle_pct;
  } phase_cfg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0]     op = '0;
  logic [COUNT_W-1:0]  count = '0;
  logic [SLOT_W-1:0]   slot = '0;
  logic [ADDR_W-1:0]   address = '0;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [COUNT_W-1:0]  granted_count;
  logic [ADDR_W-1:0]   cpu_address;
  logic [ADDR_W-1:0]   gpu_address;
  logic                gpu_valid;
  logic                last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  always #2 clk = ~clk;

  descriptor_slot_allocator_top DUT (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .op(op), .count(count), .slot(slot), .address(address),
    .done(done), .status(status), .slot_index(slot_index), .granted_count(granted_count),
    .cpu_address(cpu_address), .gpu_address(gpu_address), .gpu_valid(gpu_valid),
    .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the allocator: registers, free map (1 = free) and free slot count
  logic [POOL_W-1:0]   sh_pool;
  logic [STRIDE_W-1:0] sh_stride;
  logic [ADDR_W-1:0]   sh_cpu_base;
  logic [ADDR_W-1:0]   sh_gpu_base;
  logic                sh_gpu_vis;
  logic [POOL_MAX-1:0] sh_free;
  int                  sh_free_cnt;

  grant_word_t grant_q[$];  // words still owed by the block
  int          errors = 0;

  function automatic int usable_slots();
    return (sh_pool > POOL_MAX) ? POOL_MAX : int'(sh_pool);
  endfunction

  function automatic void recount_free();
    sh_free_cnt = 0;
    for (int s = 0; s < usable_slots(); s++)
      if (sh_free[s]) sh_free_cnt++;
  endfunction

  function automatic void owe_word(logic [STATUS_W-1:0] st, int idx, int gc, bit with_addr,
                                   bit lst);
    grant_word_t w;
    logic [ADDR_W-1:0] off;
    off = ADDR_W'(idx) * ADDR_W'(sh_stride);
    w.status        = st;
    w.slot_index    = SLOT_W'(idx);
    w.granted_count = COUNT_W'(gc);
    w.cpu_address   = with_addr ? sh_cpu_base + off : '0;
    w.gpu_address   = (with_addr && sh_gpu_vis) ? sh_gpu_base + off : '0;
    w.gpu_valid     = with_addr && sh_gpu_vis;
    w.last          = lst;
    grant_q.push_back(w);
  endfunction

  function automatic int first_free_slot();
    for (int s = 0; s < usable_slots(); s++)
      if (sh_free[s]) return s;
    return 0;
  endfunction

  // updates the shadow for one accepted request and queues the words it owes
  function automatic void predict_grants(logic [OP_W-1:0] rop, logic [COUNT_W-1:0] rcnt,
                                         logic [SLOT_W-1:0] rsl, logic [ADDR_W-1:0] raddr);
    int n, s, run, first, idx_i, c;
    bit found;
    logic [ADDR_W-1:0] off, idx;
    n = usable_slots();
    c = int'(rcnt);
    case (rop)
      OP_ALLOC_ONE: begin
        if (sh_free_cnt == 0) begin
          owe_word(ST_NO_SPACE, 0, 0, 0, 1);
        end else begin
          s = first_free_slot();
          sh_free[s] = 1'b0;
          sh_free_cnt--;
          owe_word(ST_OK, s, 1, 1, 1);
        end
      end
      OP_ALLOC_MANY: begin
        if (c == 0 || c > BATCH_MAX || sh_free_cnt < c) begin
          owe_word(ST_NO_SPACE, 0, 0, 0, 1);
        end else begin
          for (int i = 0; i < c; i++) begin
            s = first_free_slot();
            sh_free[s] = 1'b0;
            sh_free_cnt--;
            owe_word(ST_OK, s, 1, 1, i + 1 == c);
          end
        end
      end
      OP_ALLOC_RANGE: begin
        found = 0;
        run = 0;
        first = 0;
        if (c != 0 && c <= BATCH_MAX && sh_free_cnt >= c) begin
          for (s = 0; s < n && !found; s++) begin
            if (sh_free[s]) begin
              if (run == 0) first = s;
              run++;
              if (run == c) found = 1;
            end else begin
              run = 0;
            end
          end
        end
        if (!found) begin
          owe_word(ST_NO_SPACE, 0, 0, 0, 1);
        end else begin
          for (int i = 0; i < c; i++) sh_free[first + i] = 1'b0;
          sh_free_cnt -= c;
          owe_word(ST_OK, first, c, 1, 1);
        end
      end
      OP_FREE_SLOT, OP_FREE_ADDR: begin
        idx_i = int'(rsl);
        if (rop == OP_FREE_ADDR) begin
          off = raddr - sh_cpu_base;
          // zero stride: only the base address itself maps, to slot zero
          if (sh_stride == 0) begin
            if (off != 0) begin
              owe_word(ST_OUTSIDE, 0, 0, 0, 1);
              return;
            end
            idx = '0;
          end else begin
            if (off % ADDR_W'(sh_stride) != 0) begin
              owe_word(ST_MISALIGNED, 0, 0, 0, 1);
              return;
            end
            idx = off / ADDR_W'(sh_stride);
          end
          if (idx >= ADDR_W'(n)) begin
            owe_word(ST_OUTSIDE, 0, 0, 0, 1);
            return;
          end
          idx_i = int'(idx);
        end else if (idx_i >= n) begin
          owe_word(ST_OUTSIDE, 0, 0, 0, 1);
          return;
        end
        // freeing an already free slot is harmless
        if (!sh_free[idx_i]) begin
          sh_free[idx_i] = 1'b1;
          sh_free_cnt++;
        end
        owe_word(ST_OK, idx_i, 0, 0, 1);
      end
      default: ;  // unknown codes are dropped without a word
    endcase
  endfunction

  // result checker: every strobed word against the oldest owed word
  always @(posedge clk) begin
    grant_word_t got, want;
    if (!rst && done) begin
      got = '{status, slot_index, granted_count, cpu_address, gpu_address, gpu_valid, last};
      if (grant_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, actual st=%0d slot=%0d cnt=%0d cpu=%h gpu=%h gv=%b l=%b",
                 $time, got.status, got.slot_index, got.granted_count, got.cpu_address,
                 got.gpu_address, got.gpu_valid, got.last);
      end else begin
        want = grant_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected st=%0d slot=%0d cnt=%0d cpu=%h gpu=%h gv=%b l=%b",
                   $time, want.status, want.slot_index, want.granted_count, want.cpu_address,
                   want.gpu_address, want.gpu_valid, want.last);
          $display("%0t:          actual   st=%0d slot=%0d cnt=%0d cpu=%h gpu=%h gv=%b l=%b",
                   $time, got.status, got.slot_index, got.granted_count, got.cpu_address,
                   got.gpu_address, got.gpu_valid, got.last);
        end
      end
    end
  end

  int idle_pct = 0;

  // present one request at a rising edge and hold it until the block takes it
  task automatic send_request(logic [OP_W-1:0] rop, logic [COUNT_W-1:0] rcnt,
                              logic [SLOT_W-1:0] rsl, logic [ADDR_W-1:0] raddr);
    start   <= 1'b1;
    op      <= rop;
    count   <= rcnt;
    slot    <= rsl;
    address <= raddr;
    // busy only moves on rising edges, so its value mid-cycle is what the edge sees
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_grants(rop, rcnt, rsl, raddr);
    // random sender gaps
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // stop sending and let every owed word arrive, plus the tail of any silent request
  task automatic drain();
    start <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // valid stays high after the write; the caller drops it after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    case (idx)
      REG_POOL_SIZE: begin
        sh_pool = POOL_W'(data);
        recount_free();
      end
      REG_SLOT_STRIDE: sh_stride = STRIDE_W'(data);
      REG_CPU_BASE:    sh_cpu_base = data;
      REG_GPU_BASE:    sh_gpu_base = data;
      REG_GPU_VISIBLE: sh_gpu_vis = data[0];
      default: ;
    endcase
  endtask

  // mostly well-formed requests, about one in seven pure noise
  task automatic random_request();
    logic [OP_W-1:0]    rop;
    logic [COUNT_W-1:0] rcnt;
    logic [SLOT_W-1:0]  rsl;
    logic [ADDR_W-1:0]  raddr;
    int pick, n;
    n = usable_slots();
    rop   = OP_ALLOC_ONE;
    rcnt  = COUNT_W'($urandom);
    rsl   = SLOT_W'($urandom);
    raddr = {$urandom, $urandom};
    if ($urandom_range(6) == 0) begin
      rop = OP_W'($urandom);
    end else begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        rop = OP_ALLOC_ONE;
      end else if (pick < 35) begin
        rop  = OP_ALLOC_MANY;
        rcnt = ($urandom_range(9) == 0) ? COUNT_W'(BATCH_MAX) : COUNT_W'($urandom_range(1, 8));
      end else if (pick < 50) begin
        rop  = OP_ALLOC_RANGE;
        rcnt = ($urandom_range(9) == 0) ? COUNT_W'(BATCH_MAX) : COUNT_W'($urandom_range(1, 16));
      end else if (pick < 75) begin
        rop = OP_FREE_SLOT;
        if ($urandom_range(4) != 0) rsl = SLOT_W'($urandom_range(n - 1));
      end else begin
        rop = OP_FREE_ADDR;
        if ($urandom_range(4) != 0)
          raddr = sh_cpu_base + ADDR_W'($urandom_range(n - 1)) * ADDR_W'(sh_stride);
      end
    end
    send_request(rop, rcnt, rsl, raddr);
  endtask

  // directed rows, pool at reset: 1024 slots, stride 32, bases zero, gpu hidden
  req_row_t dir_rows[] = '{
    // first two single allocations hand out slots zero and one
    '{OP_ALLOC_ONE,   7'd0,   10'd0,    64'd0,   1, ST_OK,         10'd0,    7'd1, 64'd0},
    '{OP_ALLOC_ONE,   7'd0,   10'd0,    64'd0,   1, ST_OK,         10'd1,    7'd1, 64'd32},
    // bad batch sizes are refused
    '{OP_ALLOC_MANY,  7'd0,   10'd0,    64'd0,   1, ST_NO_SPACE,   10'd0,    7'd0, 64'd0},
    '{OP_ALLOC_MANY,  7'd65,  10'd0,    64'd0,   1, ST_NO_SPACE,   10'd0,    7'd0, 64'd0},
    '{OP_ALLOC_MANY,  7'd127, 10'd0,    64'd0,   1, ST_NO_SPACE,   10'd0,    7'd0, 64'd0},
    '{OP_ALLOC_RANGE, 7'd0,   10'd0,    64'd0,   1, ST_NO_SPACE,   10'd0,    7'd0, 64'd0},
    '{OP_ALLOC_RANGE, 7'd127, 10'd0,    64'd0,   1, ST_NO_SPACE,   10'd0,    7'd0, 64'd0},
    '{OP_ALLOC_MANY,  7'd64,  10'd0,    64'd0,   0, ST_OK,         10'd0,    7'd0, 64'd0},
    '{OP_ALLOC_RANGE, 7'd64,  10'd0,    64'd0,   0, ST_OK,         10'd0,    7'd0, 64'd0},
    '{OP_ALLOC_RANGE, 7'd1,   10'd0,    64'd0,   0, ST_OK,         10'd0,    7'd0, 64'd0},
    // top slot was never taken: double free
    '{OP_FREE_SLOT,   7'd0,   10'd1023, 64'd0,   1, ST_OK,         10'd1023, 7'd0, 64'd0},
    '{OP_FREE_SLOT,   7'd0,   10'd0,    64'd0,   1, ST_OK,         10'd0,    7'd0, 64'd0},
    '{OP_FREE_SLOT,   7'd0,   10'd0,    64'd0,   1, ST_OK,         10'd0,    7'd0, 64'd0},
    '{OP_FREE_ADDR,   7'd0,   10'd0,    64'd33,  1, ST_MISALIGNED, 10'd0,    7'd0, 64'd0},
    '{OP_FREE_ADDR,   7'd0,   10'd0,    64'd32768, 1, ST_OUTSIDE,  10'd0,    7'd0, 64'd0},
    '{OP_FREE_ADDR,   7'd0,   10'd0,    64'd64,  1, ST_OK,         10'd2,    7'd0, 64'd0},
    '{OP_FREE_ADDR,   7'd0,   10'd0,    '1,      1, ST_MISALIGNED, 10'd0,    7'd0, 64'd0},
    // unknown codes produce nothing
    '{3'd5,           7'd1,   10'd0,    64'd0,   0, ST_OK,         10'd0,    7'd0, 64'd0},
    '{3'd7,           '1,     '1,       '1,      0, ST_OK,         10'd0,    7'd0, 64'd0},
    '{OP_ALLOC_ONE,   7'd0,   10'd0,    64'd0,   0, ST_OK,         10'd0,    7'd0, 64'd0},
    '{OP_ALLOC_MANY,  7'd3,   10'd0,    64'd0,   0, ST_OK,         10'd0,    7'd0, 64'd0}
  };

  // phases sweep the register extremes: tiny pool, oversize pool, zero and huge strides,
  // wrapping bases, gpu on and off
  phase_cfg_t phases[] = '{
    '{11'd1024, 13'd32,   64'd0, 64'd0, 1'b0, 0},
    '{11'd1,    13'd0,    '1,    64'd0, 1'b1, 67},
    '{11'd2047, 13'd8191, 64'hFFFF_FFFF_FFFF_0000, '1, 1'b1, 8},
    '{11'd100,  13'd1,    64'd0, 64'h1234_5678_9ABC_DEF0, 1'b0, 67},
    '{11'd300,  13'd4096, 64'h8000_0000_0000_0000, 64'h0000_0000_0010_0000, 1'b1, 0}
  };

  initial begin
    grant_word_t typed_word;
    sh_pool     = RST_POOL_SIZE;
    sh_stride   = RST_SLOT_STRIDE;
    sh_cpu_base = '0;
    sh_gpu_base = '0;
    sh_gpu_vis  = 1'b0;
    sh_free     = '1;
    recount_free();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // first request waits for busy low
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].cnt, dir_rows[i].sl, dir_rows[i].addr);
      if (dir_rows[i].typed) begin
        // swap in the hand-written word for the one just predicted
        typed_word = grant_q.pop_back();
        typed_word = '{dir_rows[i].st, dir_rows[i].idx, dir_rows[i].gc, dir_rows[i].cpu,
                       64'd0, 1'b0, 1'b1};
        grant_q.push_back(typed_word);
      end
    end

    foreach (phases[p]) begin
      drain();
      write_reg(REG_POOL_SIZE,   ADDR_W'(phases[p].pool));
      write_reg(REG_SLOT_STRIDE, ADDR_W'(phases[p].stride));
      write_reg(REG_CPU_BASE,    phases[p].cpu);
      write_reg(REG_GPU_BASE,    phases[p].gpu);
      write_reg(REG_GPU_VISIBLE, ADDR_W'(phases[p].vis));
      cfg_valid <= 1'b0;
      idle_pct = phases[p].idle_pct;
      for (int k = 0; k < 30; k++) begin
        // hold off mid-phase until the block has nothing left owed
        if (p == 4 && k == 15) begin
          start <= 1'b0;
          do @(posedge clk); while (grant_q.size() != 0);
        end
        random_request();
      end
    end

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/dsa_pkg.sv
sv/descriptor_slot_allocator_top.sv
verif/tb_descriptor_slot_allocator_top.sv
